// File: design/wildcard_glob_matcher_defines.svh
// Assertion macros shared by the wildcard glob matcher modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication
`define WGM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wgm_pkg.sv
// Types and constants for the wildcard glob matcher.
// Used by wgm_pattern, wgm_nfa and wildcard_glob_matcher.
`default_nettype none

package wgm_pkg;

    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CHAR_W-1:0] ANY_CHAR_RESET = 8'd63;
    localparam logic [CHAR_W-1:0] ALL_CHAR_RESET = 8'd42;
    localparam logic [CHAR_W-1:0] NUL_CHAR       = 8'd0;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_LITERAL = 2'd2,
        FUNC_END     = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANY_CHAR = 1'b0,
        REG_ALL_CHAR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              fire;
        func_t             func;
        logic [CHAR_W-1:0] pattern_char;
        logic [CHAR_W-1:0] literal_char;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: input register, output register, handshakes.
// Instantiates wgm_pattern and wgm_nfa; uses wgm_pkg and the assertion macros.
//
//   port group   dir  payload (low bit first)
//   s_*          in   tuser: func[1:0]; tdata: pattern_char, literal_char
//   m_*          out  tdata: matched, pattern_overflow, zero fill
//   cfg_*        in   index 0 any_char, index 1 all_char
//
// One item per clock sustained unless a held result stalls an end-of-literal item;
// m_tvalid rises once the end-of-literal item has passed the input register and then
// the result register. The star closure and position step are combinational.
// rst_n clears the pattern length, overflow flag and both handshakes, and restarts the active set.
// A held result stalls an end-of-literal item in the input register and the input
// behind it; other items pass under the held result.
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN_LENGTH = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [15:0]                      s_tdata,   // pattern_char, literal_char
    input  wire  [1:0]                       s_tuser,   // func
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // matched, pattern_overflow, 6'b0
    input  wire                              cfg_wr_en,
    input  wire  [wgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [wgm_pkg::CFG_W-1:0]        cfg_data
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_LENGTH + 1);

    logic                          in_vld_reg;
    cmd_t                          in_reg;
    logic                          out_vld_reg;
    logic [1:0]                    out_reg;
    logic                          advance;
    cmd_t                          cmd;
    logic [MAX_PATTERN_LENGTH-1:0] star_vec;
    logic [MAX_PATTERN_LENGTH-1:0] step_vec;
    logic [LEN_W-1:0]              length;
    logic                          overflow;
    logic                          matched;

    assign advance  = in_vld_reg &&
                      ((in_reg.func != FUNC_END) || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_comb
    begin
        cmd      = in_reg;
        cmd.fire = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (advance && (in_reg.func == FUNC_END))
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.fire         <= 1'b1;
            in_reg.func         <= func_t'(s_tuser);
            in_reg.pattern_char <= s_tdata[7:0];
            in_reg.literal_char <= s_tdata[15:8];
        end
        if (advance && (in_reg.func == FUNC_END))
            out_reg <= {overflow, matched};
    end

    wgm_pattern #(
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
        .LEN_W              (LEN_W)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .star_vec  (star_vec),
        .step_vec  (step_vec),
        .length    (length),
        .overflow  (overflow)
    );

    wgm_nfa #(
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
        .LEN_W              (LEN_W)
    ) u_nfa (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .star_vec (star_vec),
        .step_vec (step_vec),
        .length   (length),
        .matched  (matched)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_reg};

    `WGM_ASSERT_NOW(a_end_blocks_on_stall, in_vld_reg && (in_reg.func == FUNC_END) && out_vld_reg && !m_tready, !s_tready, "end item advanced over a held result")
    `WGM_ASSERT_NEXT(a_end_gives_result, advance && (in_reg.func == FUNC_END), m_tvalid, "end item produced no result")
    `WGM_ASSERT_NOW(a_empty_input_ready, !in_vld_reg, s_tready, "empty input register not ready")

endmodule

`default_nettype wire

// File: design/wgm_pattern.sv
// Pattern store, length, overflow flag and the two wildcard registers.
// Classifies every stored position against the current literal byte; uses wgm_pkg.
`default_nettype none

module wgm_pattern #(
    parameter int MAX_PATTERN_LENGTH = 32,
    parameter int LEN_W              = $clog2(MAX_PATTERN_LENGTH + 1)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [wgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [wgm_pkg::CFG_W-1:0]        cfg_data,
    input  wgm_pkg::cmd_t                    cmd,
    output logic [MAX_PATTERN_LENGTH-1:0]    star_vec,
    output logic [MAX_PATTERN_LENGTH-1:0]    step_vec,
    output logic [LEN_W-1:0]                 length,
    output logic                             overflow
);
    import wgm_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PATTERN_LENGTH);

    logic [CHAR_W-1:0] store_reg [MAX_PATTERN_LENGTH];
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic [CHAR_W-1:0] any_char_reg;
    logic [CHAR_W-1:0] all_char_reg;
    logic              append_ok;

    assign append_ok = cmd.fire && (cmd.func == FUNC_APPEND) &&
                       (cmd.pattern_char != NUL_CHAR);

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (cmd.fire && (cmd.func == FUNC_CLEAR))
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (append_ok)
        begin
            if (length_reg < FULL_LEN)
                length_next = length_reg + LEN_W'(1);
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
            any_char_reg <= ANY_CHAR_RESET;
            all_char_reg <= ALL_CHAR_RESET;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ANY_CHAR: any_char_reg <= cfg_data;
                    REG_ALL_CHAR: all_char_reg <= cfg_data;
                    default:      any_char_reg <= any_char_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATTERN_LENGTH; i++)
        begin
            if (append_ok && (length_reg == LEN_W'(i)))
                store_reg[i] <= cmd.pattern_char;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_LENGTH; i++)
        begin
            star_vec[i] = (LEN_W'(i) < length_reg) && (store_reg[i] == all_char_reg);
            step_vec[i] = (LEN_W'(i) < length_reg) && (store_reg[i] != all_char_reg) &&
                          ((store_reg[i] == any_char_reg) ||
                           (store_reg[i] == cmd.literal_char));
        end
    end

    assign length   = length_reg;
    assign overflow = overflow_reg;

endmodule

`default_nettype wire

// File: design/wgm_nfa.sv
// Active position set: star closure by prefix scan, literal step and end check.
// Takes position classes from wgm_pattern; uses wgm_pkg and the assertion macros.
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wgm_nfa #(
    parameter int MAX_PATTERN_LENGTH = 32,
    parameter int LEN_W              = $clog2(MAX_PATTERN_LENGTH + 1)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wgm_pkg::cmd_t                    cmd,
    input  wire  [MAX_PATTERN_LENGTH-1:0]    star_vec,
    input  wire  [MAX_PATTERN_LENGTH-1:0]    step_vec,
    input  wire  [LEN_W-1:0]                 length,
    output logic                             matched
);
    import wgm_pkg::*;

    localparam int NPOS  = MAX_PATTERN_LENGTH + 1;
    localparam int LEVELS = $clog2(NPOS);
    localparam logic [NPOS-1:0] RESTART = NPOS'(1);

    logic [NPOS-1:0] active_reg;
    logic [NPOS-1:0] active_next;
    logic [NPOS-1:0] closed;
    logic [NPOS-1:0] stepped;
    logic [NPOS-1:0] star_ext;

    assign star_ext = {1'b0, star_vec};

    // closed[j] = active[j] | (star[j-1] & closed[j-1]), as a log-depth scan
    always_comb
    begin
        logic [NPOS-1:0] gs;
        logic [NPOS-1:0] ps;
        logic [NPOS-1:0] gn;
        logic [NPOS-1:0] pn;
        gs = active_reg;
        ps = {star_vec, 1'b0};
        for (int s = 0; s < LEVELS; s++)
        begin
            gn = gs;
            pn = ps;
            for (int j = 0; j < NPOS; j++)
            begin
                if (j >= (1 << s))
                begin
                    gn[j] = gs[j] | (ps[j] & gs[j - (1 << s)]);
                    pn[j] = ps[j] & ps[j - (1 << s)];
                end
            end
            gs = gn;
            ps = pn;
        end
        closed = gs;
    end

    always_comb
    begin
        stepped[0] = closed[0] & star_ext[0];
        for (int j = 1; j < NPOS; j++)
            stepped[j] = (closed[j] & star_ext[j]) | (closed[j-1] & step_vec[j-1]);
    end

    always_comb
    begin
        active_next = active_reg;
        if (cmd.fire)
        begin
            case (cmd.func)
                FUNC_CLEAR:   active_next = RESTART;
                FUNC_APPEND:  active_next = active_reg;
                FUNC_LITERAL:
                begin
                    if (cmd.literal_char != NUL_CHAR)
                        active_next = stepped;
                end
                FUNC_END:     active_next = RESTART;
                default:      active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= RESTART;
        else
            active_reg <= active_next;
    end

    assign matched = closed[length];

    `WGM_ASSERT_NEXT(a_clear_restarts, cmd.fire && (cmd.func == FUNC_CLEAR), active_reg == RESTART, "clear did not restart the active set")
    `WGM_ASSERT_NEXT(a_end_restarts, cmd.fire && (cmd.func == FUNC_END), active_reg == RESTART, "end of literal did not restart the active set")
    `WGM_ASSERT_NEXT(a_append_keeps, cmd.fire && (cmd.func == FUNC_APPEND), active_reg == $past(active_reg), "append changed the active set")

endmodule

`default_nettype wire
